>>> hdl/i2cms_pkg.sv
// ---------------------------------------------------------------------------
// i2cms_pkg
// Types, command codes and phase counts shared by the I2C bit sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // command codes as carried on the input stream
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_SACK  = 3'd4,
        CMD_RACK  = 3'd5
    } cmd_t;

    localparam int PHASE_W = 5;
    localparam int SUB_W   = 2;

    // phase index of the final bit on a byte transfer
    localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE = 5'd23;
    localparam logic [7:0]         MSB_MASK        = 8'h80;

    // one classified tick as it travels from front to back
    typedef struct packed {
        logic       cmd_ok;
        cmd_t       func;
        logic [7:0] tx_byte;
        logic       tx_ack;
        logic       sda_in;
    } item_t;

    // line and status values produced for one tick
    typedef struct packed {
        logic       rx_ack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } result_t;

    // index of the final phase of each command
    function automatic logic [PHASE_W-1:0] last_phase(input cmd_t cmd);
        logic [PHASE_W-1:0] lp;
        case (cmd)
            CMD_START: lp = 5'd3;
            CMD_STOP:  lp = 5'd2;
            CMD_WRITE: lp = 5'd23;
            CMD_READ:  lp = 5'd23;
            CMD_SACK:  lp = 5'd2;
            CMD_RACK:  lp = 5'd4;
            default:   lp = 5'd4;
        endcase
        return lp;
    endfunction

endpackage

`default_nettype wire

>>> hdl/i2cms_front.sv
// ---------------------------------------------------------------------------
// i2cms_front
// Unpacks an input transfer and marks whether it offers a legal command.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_front (
    input  wire logic [15:0]     s_tdata,
    input  wire logic [3:0]      s_tuser,
    output i2cms_pkg::item_t     item
);

    logic [2:0] func_raw;

    // command code and validity from tuser, payload bits from tdata
    always_comb begin
        func_raw       = s_tuser[3:1];
        item.func      = i2cms_pkg::cmd_t'(func_raw);
        item.cmd_ok    = s_tuser[0] && (func_raw <= 3'(i2cms_pkg::CMD_RACK));
        item.tx_byte   = s_tdata[7:0];
        item.tx_ack    = s_tdata[8];
        item.sda_in    = s_tdata[9];
    end

endmodule

`default_nettype wire

>>> hdl/i2cms_queue.sv
// ---------------------------------------------------------------------------
// i2cms_queue
// Two-entry queue that lets the front take ticks while the back is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output      logic              wr_ready,
    input  wire i2cms_pkg::item_t  wr_item,
    output      logic              rd_valid,
    input  wire logic              rd_ready,
    output      i2cms_pkg::item_t  rd_item
);

    i2cms_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2cms_back.sv
// ---------------------------------------------------------------------------
// i2cms_back
// Runs one pin phase per tick and holds the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire i2cms_pkg::item_t  in_item,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      i2cms_pkg::result_t out_res
);

    i2cms_pkg::cmd_t                      command_reg, command_next;
    logic [i2cms_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic [i2cms_pkg::SUB_W-1:0]          sub_reg, sub_next;
    logic                                 active_reg, active_next;
    logic [7:0]                           shift_reg, shift_next;
    logic                                 scl_reg, scl_next;
    logic                                 sda_reg, sda_next;
    logic [7:0]                           rx_byte_reg, rx_byte_next;
    logic                                 rx_ack_reg, rx_ack_next;
    logic                                 out_valid_reg;
    i2cms_pkg::result_t                   out_res_reg, out_res_next;

    logic                                 step;
    logic                                 launch;
    logic                                 run;
    logic                                 done;
    i2cms_pkg::cmd_t                      cmd;
    logic [i2cms_pkg::PHASE_W-1:0]        p;
    logic [i2cms_pkg::SUB_W-1:0]          sub;
    logic [7:0]                           shift_cur;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // phase engine: one phase of the running or newly launched command
    always_comb begin
        launch    = !active_reg && in_item.cmd_ok;
        run       = active_reg || launch;
        cmd       = launch ? in_item.func : command_reg;
        p         = launch ? '0 : phase_reg;
        sub       = launch ? '0 : sub_reg;
        if (launch) begin
            shift_cur = (in_item.func == i2cms_pkg::CMD_WRITE) ? in_item.tx_byte : 8'd0;
        end else begin
            shift_cur = shift_reg;
        end

        command_next = cmd;
        shift_next   = shift_cur;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_byte_next = rx_byte_reg;
        rx_ack_next  = rx_ack_reg;
        done         = 1'b0;
        active_next  = active_reg;
        phase_next   = phase_reg;
        sub_next     = sub_reg;

        if (run) begin
            case (cmd)
                i2cms_pkg::CMD_START: begin
                    case (p[1:0])
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                i2cms_pkg::CMD_STOP: begin
                    case (p[1:0])
                        2'd0:    sda_next = 1'b0;
                        2'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                i2cms_pkg::CMD_WRITE: begin
                    case (sub)
                        2'd0:    sda_next = |(shift_cur & i2cms_pkg::MSB_MASK);
                        2'd1:    scl_next = 1'b1;
                        default: begin
                            scl_next   = 1'b0;
                            shift_next = {shift_cur[6:0], 1'b0};
                        end
                    endcase
                end
                i2cms_pkg::CMD_READ: begin
                    case (sub)
                        2'd0:    scl_next = 1'b1;
                        2'd1:    shift_next = {shift_cur[6:0], in_item.sda_in};
                        default: begin
                            scl_next = 1'b0;
                            if (p == i2cms_pkg::BYTE_LAST_PHASE) begin
                                rx_byte_next = shift_cur;
                            end
                        end
                    endcase
                end
                i2cms_pkg::CMD_SACK: begin
                    case (p[1:0])
                        2'd0:    sda_next = in_item.tx_ack;
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                default: begin
                    case (p[2:0])
                        3'd0:    sda_next    = 1'b1;
                        3'd1:    scl_next    = 1'b0;
                        3'd2:    scl_next    = 1'b1;
                        3'd3:    rx_ack_next = in_item.sda_in;
                        default: scl_next    = 1'b0;
                    endcase
                end
            endcase

            // advance or finish
            if (p == i2cms_pkg::last_phase(cmd)) begin
                done        = 1'b1;
                active_next = 1'b0;
                phase_next  = '0;
                sub_next    = '0;
            end else begin
                active_next = 1'b1;
                phase_next  = p + 5'd1;
                sub_next    = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
            end
        end

        out_res_next.scl_level = scl_next;
        out_res_next.sda_level = sda_next;
        out_res_next.busy_res  = active_next;
        out_res_next.done_res  = done;
        out_res_next.rx_byte   = rx_byte_next;
        out_res_next.rx_ack    = rx_ack_next;
    end

    // sequencer state, committed only when a tick is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg   <= i2cms_pkg::CMD_START;
            phase_reg     <= '0;
            sub_reg       <= '0;
            active_reg    <= 1'b0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_byte_reg   <= 8'd0;
            rx_ack_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                command_reg <= command_next;
                phase_reg   <= phase_next;
                sub_reg     <= sub_next;
                active_reg  <= active_next;
                shift_reg   <= shift_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rx_byte_reg <= rx_byte_next;
                rx_ack_reg  <= rx_ack_next;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= out_res_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2c_master_bit_sequencer.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master line sequencer: one pin phase per input transfer.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_       | in  | tx_byte[7:0] tx_ack[8] sda_in[9]        | cmd_valid[0] func[3:1]
//  m_       | out | scl[0] sda[1] busy[2] done[3]           | -
//           |     | rx_byte[11:4] rx_ack[12]                |
//
//  one input transfer is taken per cycle while the m_ side is not stalled; each gives one output transfer
//  an input transfer is registered in the two-entry queue, then in the output register
//  the phase engine steps once per tick, state lives in the back stage
//  aresetn clears the queue, the output valid and the line state (lines released)
//  a stalled m_ side fills the queue, then s_tready drops
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // tx_byte, tx_ack, sda_in, zero pad
    input  wire logic [3:0]  s_tuser,   // cmd_valid, func
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata    // scl_level, sda_level, busy_res, done_res,
                                        // rx_byte, rx_ack, zero pad
);

    i2cms_pkg::item_t   front_item;
    i2cms_pkg::item_t   queue_item;
    i2cms_pkg::result_t res;
    logic               queue_valid;
    logic               queue_ready;

    // decode
    i2cms_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    // decoupling queue
    i2cms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    // phase engine and output register
    i2cms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_item   (queue_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'b000, res};

endmodule

`default_nettype wire

>>> hdl/i2cms_checker.sv
// ---------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the I2C bit sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [3:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // a finished command never reports busy on the same tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done and busy on the same tick");

    // no result right after a reset edge
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // queue is empty after a reset edge, so input is ready
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
